// File: sv/source_text_tokenizer_unit_macros.svh
// Assertion macros for the source text tokenizer unit.
// Used by the modules that carry concurrent checks; no dependencies.
`ifndef SOURCE_TEXT_TOKENIZER_UNIT_MACROS_SVH
`define SOURCE_TEXT_TOKENIZER_UNIT_MACROS_SVH
`ifndef SYNTH
`define STT_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define STT_ASSERT_IMPL(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error("%m failed");
`else
`define STT_ASSERT(label, clk, rst_n, prop)
`define STT_ASSERT_IMPL(label, clk, rst_n, a, b)
`endif
`endif

// File: sv/stt_pkg.sv
// Shared types, codes and character tables for the source text tokenizer.
// No dependencies.
`timescale 1ns / 1ps
package stt_pkg;

  localparam int LINE_BITS = 24;
  localparam int LENGTH_BITS = 16;
  localparam int KW_COUNT = 17;
  localparam int MAX_RES = 4;
  localparam int RES_IDX_BITS = 2;
  localparam int RES_CNT_BITS = 3;

  localparam logic [1:0] KIND_VALUE = 2'd0;
  localparam logic [1:0] KIND_END = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [2:0] TT_IDENT = 3'd0;
  localparam logic [2:0] TT_KEYWORD = 3'd1;
  localparam logic [2:0] TT_NUMBER = 3'd2;
  localparam logic [2:0] TT_OPER = 3'd3;
  localparam logic [2:0] TT_SYMBOL = 3'd4;
  localparam logic [2:0] TT_STRING = 3'd5;
  localparam logic [2:0] TT_EOF = 3'd6;

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_UNKNOWN = 2'd1;
  localparam logic [1:0] ERR_UNTERM = 2'd2;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_EOS = 1'b1;

  typedef enum logic [7:0] {
    MODE_IDLE = 8'b0000_0001,
    MODE_WORD = 8'b0000_0010,
    MODE_NUM  = 8'b0000_0100,
    MODE_OPER = 8'b0000_1000,
    MODE_STR  = 8'b0001_0000,
    MODE_ESC  = 8'b0010_0000,
    MODE_CMT  = 8'b0100_0000,
    MODE_ERR  = 8'b1000_0000
  } lex_mode_t;

  typedef struct packed {
    logic       command;
    logic [7:0] char_byte;
  } stt_in_t;

  typedef struct packed {
    logic [1:0]             result_kind;
    logic [2:0]             token_type;
    logic [7:0]             value_byte;
    logic [4:0]             keyword_number;
    logic [LENGTH_BITS-1:0] token_length;
    logic [LINE_BITS-1:0]   line_number;
    logic [1:0]             error_code;
    logic                   last_of_run;
  } stt_out_t;

  typedef struct packed {
    logic [RES_CNT_BITS-1:0] count;
    stt_out_t [MAX_RES-1:0]  res;
  } stt_batch_t;

  typedef logic [7:0] kw_chars_t [KW_COUNT][9];

  localparam kw_chars_t KW_CHARS = '{
    '{"i","f",0,0,0,0,0,0,0},
    '{"e","l","s","e",0,0,0,0,0},
    '{"w","h","i","l","e",0,0,0,0},
    '{"r","e","t","u","r","n",0,0,0},
    '{"w","r","i","t","e",0,0,0,0},
    '{"r","e","a","d",0,0,0,0,0},
    '{"f","o","r",0,0,0,0,0,0},
    '{"i","n","c","l","u","d","e",0,0},
    '{"l","e","t",0,0,0,0,0,0},
    '{"c","o","n","s","t",0,0,0,0},
    '{"f","u","n","c","t","i","o","n",0},
    '{"c","l","a","s","s",0,0,0,0},
    '{"p","u","b","l","i","c",0,0,0},
    '{"p","r","i","v","a","t","e",0,0},
    '{"p","r","o","t","e","c","t","e","d"},
    '{"i","n",0,0,0,0,0,0,0},
    '{"f","r","o","m",0,0,0,0,0}
  };

  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd2, 4'd4, 4'd5, 4'd6, 4'd5, 4'd4, 4'd3, 4'd7, 4'd3,
    4'd5, 4'd8, 4'd5, 4'd6, 4'd7, 4'd9, 4'd2, 4'd4
  };

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_oper(input logic [7:0] c);
    return c == "+" || c == "-" || c == "*" || c == "/" || c == "%" || c == "=" ||
           c == "&" || c == "|" || c == "<" || c == ">" || c == "!" || c == "^";
  endfunction

  function automatic logic is_symbol(input logic [7:0] c);
    return c == ";" || c == "(" || c == ")" || c == "{" || c == "}" || c == "[" ||
           c == "]" || c == "," || c == ":" || c == "." || c == "@";
  endfunction

  function automatic logic is_pair(input logic [7:0] a, input logic [7:0] b);
    return (b == "=" && (a == "=" || a == "!" || a == "<" || a == ">" || a == "+" ||
                         a == "-" || a == "*" || a == "/" || a == "%" || a == "&" ||
                         a == "|" || a == "^")) ||
           (a == b && (a == "&" || a == "|" || a == "+" || a == "-" || a == "<" ||
                       a == ">"));
  endfunction

endpackage

// File: sv/stt_lexer.sv
// Lexer core: one combinational pass over registered state that turns an input request into up to four results.
// Depends on stt_pkg.
`timescale 1ns / 1ps
module stt_lexer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  stt_pkg::stt_in_t    item,
  output stt_pkg::stt_batch_t batch
);
  import stt_pkg::*;

  lex_mode_t              mode_r, mode_nxt;
  logic [7:0]             held_r, held_nxt;
  logic                   dq_r, dq_nxt;
  logic                   dot_r, dot_nxt;
  logic [LINE_BITS-1:0]   line_r, line_nxt;
  logic [LENGTH_BITS-1:0] vcnt_r, vcnt_nxt;
  logic [KW_COUNT-1:0]    kwm_r, kwm_nxt;
  logic [3:0]             kwp_r, kwp_nxt;
  stt_batch_t             b;

  localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};
  localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

  function automatic stt_out_t mk(input logic [1:0] k, input logic [2:0] t,
                                  input logic [7:0] v, input logic [4:0] kn,
                                  input logic [LENGTH_BITS-1:0] len,
                                  input logic [LINE_BITS-1:0] ln, input logic [1:0] e);
    stt_out_t r;
    r.result_kind = k;
    r.token_type = t;
    r.value_byte = v;
    r.keyword_number = kn;
    r.token_length = len;
    r.line_number = ln;
    r.error_code = e;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  always_comb begin
    logic [7:0] c;
    logic end_tok;
    logic start;
    logic kw_hit;
    logic [4:0] kw_num;
    logic [KW_COUNT-1:0] kwm_step;
    logic [LENGTH_BITS-1:0] vinc;
    c = item.char_byte;
    mode_nxt = mode_r;
    held_nxt = held_r;
    dq_nxt = dq_r;
    dot_nxt = dot_r;
    line_nxt = line_r;
    vcnt_nxt = vcnt_r;
    kwm_nxt = kwm_r;
    kwp_nxt = kwp_r;
    b = '0;
    end_tok = 1'b0;
    start = 1'b0;
    vinc = (vcnt_r != LEN_MAX) ? vcnt_r + 1'b1 : vcnt_r;
    kw_hit = 1'b0;
    kw_num = '0;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      if (kwm_r[k] && KW_LEN[k] == kwp_r) begin
        kw_hit = 1'b1;
        kw_num = 5'(k);
      end
    end
    for (int k = 0; k < KW_COUNT; k++) begin
      kwm_step[k] = kwm_r[k] && kwp_r < KW_LEN[k] && KW_CHARS[k][kwp_r] == c;
    end
    if (item.command == CMD_EOS) begin
      b.count = 3'd1;
      case (mode_r)
        MODE_WORD: begin
          b.res[0] = mk(KIND_END, kw_hit ? TT_KEYWORD : TT_IDENT, 8'd0,
                        kw_hit ? kw_num : 5'd0, vcnt_r, line_r, ERR_NONE);
          b.count = 3'd2;
        end
        MODE_NUM: begin
          b.res[0] = mk(KIND_END, TT_NUMBER, 8'd0, 5'd0, vcnt_r, line_r, ERR_NONE);
          b.count = 3'd2;
        end
        MODE_OPER: begin
          b.res[0] = mk(KIND_VALUE, TT_OPER, held_r, 5'd0, '0, line_r, ERR_NONE);
          b.res[1] = mk(KIND_END, TT_OPER, 8'd0, 5'd0, vinc, line_r, ERR_NONE);
          b.count = 3'd3;
        end
        MODE_STR, MODE_ESC: begin
          b.res[0] = mk(KIND_ERROR, TT_IDENT, 8'd0, 5'd0, '0, line_r, ERR_UNTERM);
          b.count = 3'd1;
        end
        MODE_ERR: b.count = 3'd0;
        default: ;
      endcase
      if (mode_r != MODE_STR && mode_r != MODE_ESC && mode_r != MODE_ERR)
        b.res[b.count[1:0] - 2'd1] = mk(KIND_END, TT_EOF, 8'd0, 5'd0, '0, line_r, ERR_NONE);
      mode_nxt = MODE_IDLE;
      held_nxt = '0;
      dq_nxt = 1'b0;
      dot_nxt = 1'b0;
      line_nxt = LINE_BITS'(1);
      vcnt_nxt = '0;
      kwm_nxt = '1;
      kwp_nxt = '0;
    end else begin
      case (mode_r)
        MODE_ERR: ;
        MODE_CMT: begin
          if (c == 8'd10) begin
            if (line_r != LINE_MAX) line_nxt = line_r + 1'b1;
            mode_nxt = MODE_IDLE;
          end
        end
        MODE_STR: begin
          if (c == (dq_r ? 8'h22 : 8'h27)) begin
            b.res[0] = mk(KIND_END, TT_STRING, 8'd0, 5'd0, vcnt_r, line_r, ERR_NONE);
            b.count = 3'd1;
            vcnt_nxt = '0;
            mode_nxt = MODE_IDLE;
          end else if (c == 8'h5C) begin
            mode_nxt = MODE_ESC;
          end else begin
            b.res[0] = mk(KIND_VALUE, TT_STRING, c, 5'd0, '0, line_r, ERR_NONE);
            b.count = 3'd1;
            vcnt_nxt = vinc;
          end
        end
        MODE_ESC: begin
          b.res[0] = mk(KIND_VALUE, TT_STRING,
                        c == "n" ? 8'd10 : (c == "t" ? 8'd9 : c), 5'd0, '0, line_r, ERR_NONE);
          b.count = 3'd1;
          vcnt_nxt = vinc;
          mode_nxt = MODE_STR;
        end
        MODE_WORD: begin
          if (is_alpha(c) || is_digit(c) || c == "_" || c[7]) begin
            b.res[0] = mk(KIND_VALUE, TT_IDENT, c, 5'd0, '0, line_r, ERR_NONE);
            b.count = 3'd1;
            vcnt_nxt = vinc;
            kwm_nxt = kwm_step;
            if (kwp_r != 4'd15) kwp_nxt = kwp_r + 1'b1;
          end else begin
            b.res[0] = mk(KIND_END, kw_hit ? TT_KEYWORD : TT_IDENT, 8'd0,
                          kw_hit ? kw_num : 5'd0, vcnt_r, line_r, ERR_NONE);
            b.count = 3'd1;
            start = 1'b1;
          end
        end
        MODE_NUM: begin
          if (is_digit(c) || (c == "." && !dot_r)) begin
            if (c == ".") dot_nxt = 1'b1;
            b.res[0] = mk(KIND_VALUE, TT_NUMBER, c, 5'd0, '0, line_r, ERR_NONE);
            b.count = 3'd1;
            vcnt_nxt = vinc;
          end else begin
            b.res[0] = mk(KIND_END, TT_NUMBER, 8'd0, 5'd0, vcnt_r, line_r, ERR_NONE);
            b.count = 3'd1;
            start = 1'b1;
          end
        end
        MODE_OPER: begin
          if (held_r == "/" && c == "/") begin
            mode_nxt = MODE_CMT;
          end else begin
            b.res[0] = mk(KIND_VALUE, TT_OPER, held_r, 5'd0, '0, line_r, ERR_NONE);
            if (is_pair(held_r, c)) begin
              b.res[1] = mk(KIND_VALUE, TT_OPER, c, 5'd0, '0, line_r, ERR_NONE);
              b.res[2] = mk(KIND_END, TT_OPER, 8'd0, 5'd0,
                            (vinc != LEN_MAX) ? vinc + 1'b1 : vinc, line_r, ERR_NONE);
              b.count = 3'd3;
              vcnt_nxt = '0;
              mode_nxt = MODE_IDLE;
            end else begin
              b.res[1] = mk(KIND_END, TT_OPER, 8'd0, 5'd0, vinc, line_r, ERR_NONE);
              b.count = 3'd2;
              start = 1'b1;
            end
          end
        end
        default: start = 1'b1;
      endcase
      if (start) begin
        mode_nxt = MODE_IDLE;
        vcnt_nxt = '0;
        if (is_space(c)) begin
          if (c == 8'd10 && line_r != LINE_MAX) line_nxt = line_r + 1'b1;
        end else if (is_alpha(c) || c[7]) begin
          mode_nxt = MODE_WORD;
          kwp_nxt = 4'd1;
          for (int k = 0; k < KW_COUNT; k++) kwm_nxt[k] = KW_CHARS[k][0] == c;
          b.res[b.count[1:0]] = mk(KIND_VALUE, TT_IDENT, c, 5'd0, '0, line_r, ERR_NONE);
          b.count = b.count + 1'b1;
          vcnt_nxt = LENGTH_BITS'(1);
        end else if (is_digit(c)) begin
          mode_nxt = MODE_NUM;
          dot_nxt = 1'b0;
          b.res[b.count[1:0]] = mk(KIND_VALUE, TT_NUMBER, c, 5'd0, '0, line_r, ERR_NONE);
          b.count = b.count + 1'b1;
          vcnt_nxt = LENGTH_BITS'(1);
        end else if (is_oper(c)) begin
          mode_nxt = MODE_OPER;
          held_nxt = c;
        end else if (is_symbol(c)) begin
          b.res[b.count[1:0]] = mk(KIND_VALUE, TT_SYMBOL, c, 5'd0, '0, line_r, ERR_NONE);
          b.res[b.count[1:0] + 2'd1] = mk(KIND_END, TT_SYMBOL, 8'd0, 5'd0,
                                          LENGTH_BITS'(1), line_r, ERR_NONE);
          b.count = b.count + 3'd2;
        end else if (c == 8'h22 || c == 8'h27) begin
          mode_nxt = MODE_STR;
          dq_nxt = c == 8'h22;
        end else begin
          b.res[b.count[1:0]] = mk(KIND_ERROR, TT_IDENT, 8'd0, 5'd0, '0, line_r, ERR_UNKNOWN);
          b.count = b.count + 1'b1;
          mode_nxt = MODE_ERR;
        end
      end
    end
    if (b.count != '0) b.res[b.count[1:0] - 2'd1].last_of_run = 1'b1;
    batch = b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      held_r <= '0;
      dq_r <= 1'b0;
      dot_r <= 1'b0;
      line_r <= LINE_BITS'(1);
      vcnt_r <= '0;
      kwm_r <= '1;
      kwp_r <= '0;
    end else if (step) begin
      mode_r <= mode_nxt;
      held_r <= held_nxt;
      dq_r <= dq_nxt;
      dot_r <= dot_nxt;
      line_r <= line_nxt;
      vcnt_r <= vcnt_nxt;
      kwm_r <= kwm_nxt;
      kwp_r <= kwp_nxt;
    end
  end

  `include "source_text_tokenizer_unit_macros.svh"
  `STT_ASSERT(a_onehot_mode, clk, rst_n, $onehot(mode_r))
  `STT_ASSERT_IMPL(a_line_nonzero, clk, rst_n, 1'b1, line_r != '0)
  `STT_ASSERT_IMPL(a_eos_resets, clk, rst_n, step && item.command == CMD_EOS, ##1 mode_r == MODE_IDLE)
endmodule

// File: sv/stt_out_queue.sv
// Result queue: takes a batch of up to four results per request and drains one per cycle while out_ready is high.
// Depends on stt_pkg.
`timescale 1ns / 1ps
module stt_out_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  stt_pkg::stt_batch_t batch,
  output logic                has_room,
  output logic                out_valid,
  input  logic                out_ready,
  output stt_pkg::stt_out_t   out_data
);
  import stt_pkg::*;

  localparam int DEPTH = 8;
  stt_out_t   mem_r [DEPTH];
  logic [2:0] rd_r, rd_nxt, wr_r, wr_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic       pop;

  assign out_valid = cnt_r != 4'd0;
  assign out_data = mem_r[rd_r];
  assign pop = out_valid && out_ready;
  assign has_room = cnt_r <= 4'd4 || (cnt_r == 4'd5 && pop);

  always_comb begin
    logic [2:0] n;
    n = push ? batch.count : 3'd0;
    wr_nxt = wr_r + n;
    rd_nxt = rd_r + {2'b0, pop};
    cnt_nxt = cnt_r + {1'b0, n} - {3'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      for (int i = 0; i < MAX_RES; i++) begin
        if (3'(i) < batch.count) mem_r[wr_r + 3'(i)] <= batch.res[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r <= '0;
      wr_r <= '0;
      cnt_r <= '0;
    end else begin
      rd_r <= rd_nxt;
      wr_r <= wr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  `include "source_text_tokenizer_unit_macros.svh"
  `STT_ASSERT_IMPL(a_no_overflow, clk, rst_n, 1'b1, cnt_r <= 4'd8)
  `STT_ASSERT_IMPL(a_push_room, clk, rst_n, push, has_room)
  `STT_ASSERT_IMPL(a_ptr_track, clk, rst_n, 1'b1, 3'(wr_r - rd_r) == cnt_r[2:0])
endmodule

// File: sv/source_text_tokenizer_unit.sv
// Top level of the source text tokenizer: lexer core feeding a result queue.
// Depends on stt_pkg, stt_lexer and stt_out_queue.
`timescale 1ns / 1ps
// Channel | Direction | Payload      | Handshake
// in_     | input     | stt_in_t     | in_valid / in_ready
// out_    | output    | stt_out_t    | out_valid / out_ready
// One request is taken per cycle while the eight-entry result queue has room for four.
// Results are registered in the result queue and drain one per cycle while out_ready is high.
// Sustained rate is one request per cycle when each request yields at most one result and out_ready stays high.
// Reset is synchronous on rst_n and empties the queue and clears lexer state.
module source_text_tokenizer_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  stt_pkg::stt_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output stt_pkg::stt_out_t out_data
);
  import stt_pkg::*;

  stt_batch_t batch;
  logic       step;

  assign step = in_valid && in_ready;

  stt_lexer u_lexer (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (in_data),
    .batch (batch)
  );

  stt_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (step),
    .batch     (batch),
    .has_room  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );
endmodule

// File: test/tb_source_text_tokenizer_unit.sv
// Testbench for the source text tokenizer unit: byte streams in, token records out.
// Depends on stt_pkg and source_text_tokenizer_unit; a built-in tokenizer predicts results.
`timescale 1ns / 1ps
module tb_source_text_tokenizer_unit;
  import stt_pkg::*;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  stt_in_t in_data;
  logic out_valid;
  logic out_ready;
  stt_out_t out_data;

  source_text_tokenizer_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  typedef enum int {LX_IDLE, LX_WORD, LX_NUM, LX_OPER, LX_STR, LX_ESC, LX_CMT, LX_ERR} lx_t;

  lx_t lx;
  logic [7:0] held_op;
  logic dq;
  logic dot;
  logic [LINE_BITS-1:0] line_cnt;
  logic [LENGTH_BITS-1:0] val_cnt;
  logic [KW_COUNT-1:0] kw_live;
  logic [3:0] kw_pos;

  stt_out_t token_queue[$];
  stt_out_t step_res[$];
  int errors = 0;
  int requests_sent = 0;
  int results_seen = 0;
  int send_idle = 0;
  int recv_idle = 0;
  bit hold_off = 0;
  longint cycles = 0;

  always begin
    clk = 1'b0; #10;
    clk = 1'b1; #10;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic stt_out_t mk(logic [1:0] k, logic [2:0] t, logic [7:0] v,
                                   logic [4:0] kn, logic [LENGTH_BITS-1:0] len,
                                   logic [1:0] e);
    stt_out_t r;
    r.result_kind = k; r.token_type = t; r.value_byte = v; r.keyword_number = kn;
    r.token_length = len; r.line_number = line_cnt; r.error_code = e; r.last_of_run = 1'b0;
    return r;
  endfunction

  task automatic lex_reset();
    lx = LX_IDLE; held_op = '0; dq = 1'b0; dot = 1'b0; line_cnt = LINE_BITS'(1);
    val_cnt = '0; kw_live = '1; kw_pos = '0;
  endtask

  task automatic line_up();
    if (line_cnt != '1) line_cnt++;
  endtask

  task automatic push_value(logic [2:0] t, logic [7:0] c);
    step_res.push_back(mk(KIND_VALUE, t, c, 5'd0, '0, ERR_NONE));
    if (val_cnt != '1) val_cnt++;
  endtask

  task automatic push_end(logic [2:0] t, logic [4:0] kn);
    step_res.push_back(mk(KIND_END, t, 8'd0, kn, val_cnt, ERR_NONE));
    val_cnt = '0;
  endtask

  task automatic word_char(logic [7:0] c);
    for (int k = 0; k < KW_COUNT; k++)
      if (kw_pos >= KW_LEN[k] || KW_CHARS[k][kw_pos] != c) kw_live[k] = 1'b0;
    if (kw_pos < 4'd15) kw_pos++;
    push_value(TT_IDENT, c);
  endtask

  task automatic finish_word();
    for (int k = 0; k < KW_COUNT; k++)
      if (kw_live[k] && KW_LEN[k] == kw_pos) begin
        push_end(TT_KEYWORD, k[4:0]);
        return;
      end
    push_end(TT_IDENT, 5'd0);
  endtask

  task automatic begin_token(logic [7:0] c);
    lx = LX_IDLE;
    val_cnt = '0;
    if (is_space(c)) begin
      if (c == "\n") line_up();
    end else if (is_alpha(c) || c >= 8'h80) begin
      lx = LX_WORD; kw_live = '1; kw_pos = '0;
      word_char(c);
    end else if (is_digit(c)) begin
      lx = LX_NUM; dot = 1'b0;
      push_value(TT_NUMBER, c);
    end else if (is_oper(c)) begin
      lx = LX_OPER; held_op = c;
    end else if (is_symbol(c)) begin
      push_value(TT_SYMBOL, c);
      push_end(TT_SYMBOL, 5'd0);
    end else if (c == "\"" || c == "'") begin
      lx = LX_STR; dq = (c == "\"");
    end else begin
      step_res.push_back(mk(KIND_ERROR, TT_IDENT, 8'd0, 5'd0, '0, ERR_UNKNOWN));
      lx = LX_ERR;
    end
  endtask

  // Works out every result one request causes and appends them to token_queue.
  task automatic tokenize_request(stt_in_t r);
    logic [7:0] c;
    c = r.char_byte;
    step_res.delete();
    if (r.command == CMD_EOS) begin
      case (lx)
        LX_WORD: finish_word();
        LX_NUM: push_end(TT_NUMBER, 5'd0);
        LX_OPER: begin
          push_value(TT_OPER, held_op);
          push_end(TT_OPER, 5'd0);
        end
        default: ;
      endcase
      if (lx == LX_STR || lx == LX_ESC)
        step_res.push_back(mk(KIND_ERROR, TT_IDENT, 8'd0, 5'd0, '0, ERR_UNTERM));
      else if (lx != LX_ERR)
        step_res.push_back(mk(KIND_END, TT_EOF, 8'd0, 5'd0, '0, ERR_NONE));
      lex_reset();
    end else begin
      case (lx)
        LX_ERR: ;
        LX_CMT: if (c == "\n") begin
          line_up(); lx = LX_IDLE;
        end
        LX_STR: begin
          if (c == (dq ? 8'h22 : 8'h27)) begin
            push_end(TT_STRING, 5'd0); lx = LX_IDLE;
          end else if (c == "\\") lx = LX_ESC;
          else push_value(TT_STRING, c);
        end
        LX_ESC: begin
          push_value(TT_STRING, c == "n" ? 8'd10 : (c == "t" ? 8'd9 : c));
          lx = LX_STR;
        end
        LX_WORD: begin
          if (is_alpha(c) || is_digit(c) || c == "_" || c >= 8'h80) word_char(c);
          else begin
            finish_word(); begin_token(c);
          end
        end
        LX_NUM: begin
          if (is_digit(c) || (c == "." && !dot)) begin
            if (c == ".") dot = 1'b1;
            push_value(TT_NUMBER, c);
          end else begin
            push_end(TT_NUMBER, 5'd0); begin_token(c);
          end
        end
        LX_OPER: begin
          if (held_op == "/" && c == "/") lx = LX_CMT;
          else begin
            push_value(TT_OPER, held_op);
            if (is_pair(held_op, c)) begin
              push_value(TT_OPER, c); push_end(TT_OPER, 5'd0); lx = LX_IDLE;
            end else begin
              push_end(TT_OPER, 5'd0); begin_token(c);
            end
          end
        end
        default: begin_token(c);
      endcase
    end
    if (step_res.size() > 0) step_res[$].last_of_run = 1'b1;
    foreach (step_res[i]) token_queue.push_back(step_res[i]);
  endtask

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) tokenize_request(in_data);
  end

  always @(posedge clk) begin
    stt_out_t e;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (token_queue.size() == 0) begin
        $error("unexpected result %p", out_data);
        errors++;
      end else begin
        e = token_queue.pop_front();
        if (out_data.result_kind !== e.result_kind) begin
          $error("result_kind exp %0d got %0d", e.result_kind, out_data.result_kind); errors++;
        end
        if (out_data.token_type !== e.token_type) begin
          $error("token_type exp %0d got %0d", e.token_type, out_data.token_type); errors++;
        end
        if (out_data.value_byte !== e.value_byte) begin
          $error("value_byte exp %0h got %0h", e.value_byte, out_data.value_byte); errors++;
        end
        if (out_data.keyword_number !== e.keyword_number) begin
          $error("keyword_number exp %0d got %0d", e.keyword_number,
                 out_data.keyword_number);
          errors++;
        end
        if (out_data.token_length !== e.token_length) begin
          $error("token_length exp %0d got %0d", e.token_length, out_data.token_length);
          errors++;
        end
        if (out_data.line_number !== e.line_number) begin
          $error("line_number exp %0d got %0d", e.line_number, out_data.line_number);
          errors++;
        end
        if (out_data.error_code !== e.error_code) begin
          $error("error_code exp %0d got %0d", e.error_code, out_data.error_code); errors++;
        end
        if (out_data.last_of_run !== e.last_of_run) begin
          $error("last_of_run exp %0d got %0d", e.last_of_run, out_data.last_of_run);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= !hold_off && ($urandom_range(99) >= recv_idle);
  end

  // Valid stays high from one accepted request into the next unless the sender idles.
  task automatic send_request(logic cmd, logic [7:0] c);
    if (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data.command <= cmd;
    in_data.char_byte <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    requests_sent++;
  endtask

  task automatic send_text(string s);
    foreach (s[i]) send_request(CMD_BYTE, s[i]);
  endtask

  task automatic send_eos();
    send_request(CMD_EOS, 8'($urandom_range(255)));
  endtask

  task automatic test_directed();
    send_text("if x1 protected functionx 3.14.5 <<=//c\n");
    send_text("a/b \"s\\n\\t\\q\" 'x\"' ;@_");
    send_eos();
    send_text("\xff\x80z += ! /");
    send_eos();
    send_text("\"ab\\");
    send_eos();
    send_request(CMD_BYTE, 8'h00);
    send_eos();
  endtask

  function automatic logic [7:0] pick_byte();
    string pool;
    pool = "abcfilnorstuw_019.;(){}+-*/=<>!&|^\"' \n\\";
    case ($urandom_range(9))
      0: return 8'($urandom_range(255));
      1: return 8'($urandom_range(255)) | 8'h80;
      default: return pool[$urandom_range(pool.len() - 1)];
    endcase
  endfunction

  task automatic test_random(int n);
    string words[8];
    words = '{"while ", "return x", "include", "let 7 ", "class(", "from.", "else\n",
              "read==b"};
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) < 3) send_text(words[$urandom_range(7)]);
      else if ($urandom_range(29) == 0) send_eos();
      else send_request(CMD_BYTE, pick_byte());
    end
    send_eos();
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_off = 1;
        repeat (60) @(posedge clk);
        hold_off = 0;
      end
      send_text("+= -- && || != <= >= ^= %= ;;;;");
    join
    send_eos();
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (token_queue.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  initial begin
    lex_reset();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle = 30; recv_idle = 75;
    test_directed();
    test_random(12);
    send_idle = 75; recv_idle = 30;
    test_random(12);
    send_idle = 0; recv_idle = 0;
    test_backpressure();
    test_random(8);
    drain();
    $display("Sent %0d requests covering words, keywords, numbers, operators, strings,",
             requests_sent);
    $display("comments and errors; checked %0d results under stalls.", results_seen);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

// File: files.f
+incdir+sv
sv/stt_pkg.sv
sv/stt_lexer.sv
sv/stt_out_queue.sv
sv/source_text_tokenizer_unit.sv
test/tb_source_text_tokenizer_unit.sv
